/* hdl/rme_pkg.sv */
// shared types and constants for the modular exponentiation block
package rme_pkg;

    localparam int VALUE_BITS     = 32;
    localparam int VALUE_CNT_BITS = 5;
    localparam int EXP_BITS       = 32;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 32;
    localparam int BYTE_BITS      = 8;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_MODULUS          = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PUBLIC_EXPONENT  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PRIVATE_EXPONENT = 2'd2;

    localparam logic FUNC_ENCRYPT = 1'b0;
    localparam logic FUNC_DECRYPT = 1'b1;

    typedef struct packed {
        logic                  func;
        logic [VALUE_BITS-1:0] value;
        logic                  last_item;
    } t_in_item;

    typedef struct packed {
        logic [VALUE_BITS-1:0] result;
        logic                  last_out;
    } t_out_item;

endpackage

/* hdl/rme_modred.sv */
// bit-serial reduction of a 32-bit operand modulo n, one operand bit per cycle
module rme_modred #(
    parameter int WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [rme_pkg::VALUE_BITS-1:0]  i_value,
    input  logic [WIDTH-1:0]                i_modulus,
    output logic                            o_done,
    output logic [WIDTH-1:0]                o_rem
);

    logic                               r_busy;
    logic                               r_done;
    logic [rme_pkg::VALUE_CNT_BITS-1:0] r_cnt;
    logic [rme_pkg::VALUE_BITS-1:0]     r_shift;
    logic [WIDTH-1:0]                   r_rem;
    logic [WIDTH:0]                     shifted;
    logic [WIDTH:0]                     wide_mod;
    logic [WIDTH-1:0]                   n_rem;

    always_comb begin
        shifted  = {r_rem, r_shift[rme_pkg::VALUE_BITS-1]};
        wide_mod = {1'b0, i_modulus};
        if ((i_modulus != '0) && (shifted >= wide_mod)) begin
            n_rem = WIDTH'(shifted - wide_mod);
        end else begin
            n_rem = shifted[WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == '0)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_shift <= i_value;
            r_rem   <= '0;
            r_cnt   <= rme_pkg::VALUE_CNT_BITS'(rme_pkg::VALUE_BITS - 1);
        end else if (r_busy) begin
            r_shift <= {r_shift[rme_pkg::VALUE_BITS-2:0], 1'b0};
            r_rem   <= n_rem;
            r_cnt   <= r_cnt - 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

/* hdl/rme_mulmod.sv */
// bit-serial modular multiplier, multiplier scanned lsb first, one bit per cycle
module rme_mulmod #(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_a,
    input  logic [WIDTH-1:0] i_b,
    input  logic [WIDTH-1:0] i_modulus,
    output logic             o_done,
    output logic [WIDTH-1:0] o_product
);

    localparam int CW = $clog2(WIDTH);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [WIDTH-1:0] r_a;
    logic [WIDTH-1:0] r_b;
    logic [WIDTH-1:0] r_acc;
    logic [WIDTH:0]   wide_mod;
    logic [WIDTH:0]   sum_acc;
    logic [WIDTH:0]   sum_dbl;
    logic [WIDTH-1:0] n_acc;
    logic [WIDTH-1:0] n_a;
    logic             reduce_on;

    always_comb begin
        wide_mod  = {1'b0, i_modulus};
        reduce_on = (i_modulus != '0);
        sum_acc   = {1'b0, r_acc} + {1'b0, r_a};
        sum_dbl   = {r_a, 1'b0};
        if (reduce_on && (sum_acc >= wide_mod)) begin
            n_acc = WIDTH'(sum_acc - wide_mod);
        end else begin
            n_acc = sum_acc[WIDTH-1:0];
        end
        if (reduce_on && (sum_dbl >= wide_mod)) begin
            n_a = WIDTH'(sum_dbl - wide_mod);
        end else begin
            n_a = sum_dbl[WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == '0)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
            r_cnt <= CW'(WIDTH - 1);
        end else if (r_busy) begin
            if (r_b[0]) begin
                r_acc <= n_acc;
            end
            r_a   <= n_a;
            r_b   <= {1'b0, r_b[WIDTH-1:1]};
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_done    = r_done;
    assign o_product = r_acc;

endmodule

/* hdl/rsa_modular_exponentiation.sv */
// top level: rsa square-and-multiply exponentiation with config registers
// exponent below two: the operand passes from S_IDLE to S_FINISH and on to the output register
// otherwise the operand is first reduced bit-serially modulo n, then one serial multiply pair
// runs per exponent bit, over L bits, L the bit length of the exponent
// one item in flight; the next input transfer can come in the cycle after the result is loaded
// synchronous active-low reset clears control and loads modulus 1 and zero exponents
module rsa_modular_exponentiation #(
    parameter int MODULUS_BITS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  rme_pkg::t_in_item                   i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output rme_pkg::t_out_item                  o_out,
    input  logic                                i_cfg_we,
    input  logic [rme_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [rme_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);

    localparam int W  = MODULUS_BITS;
    localparam int EW = (W > rme_pkg::VALUE_BITS) ? W : rme_pkg::VALUE_BITS;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_REDUCE = 5'b00010,
        S_LAUNCH = 5'b00100,
        S_POW    = 5'b01000,
        S_FINISH = 5'b10000
    } t_state;

    t_state                            r_state;
    logic [W-1:0]                      r_modulus;
    logic [rme_pkg::EXP_BITS-1:0]      r_pub_exp;
    logic [rme_pkg::EXP_BITS-1:0]      r_priv_exp;
    logic                              r_func;
    logic                              r_last;
    logic                              r_pass;
    logic [rme_pkg::VALUE_BITS-1:0]    r_operand;
    logic [rme_pkg::EXP_BITS-1:0]      r_exp;
    logic [W-1:0]                      r_acc;
    logic [W-1:0]                      r_base;
    logic                              r_out_valid;
    rme_pkg::t_out_item                r_out;

    logic                              in_xfer;
    logic [rme_pkg::EXP_BITS-1:0]      sel_exp;
    logic [rme_pkg::VALUE_BITS-1:0]    sel_operand;
    logic                              sel_pass;
    logic                              red_start;
    logic                              red_done;
    logic [W-1:0]                      red_rem;
    logic                              mul_start;
    logic                              acc_done;
    logic                              sq_done;
    logic [W-1:0]                      acc_prod;
    logic [W-1:0]                      sq_prod;
    logic [EW-1:0]                     acc_ext;
    logic [EW-1:0]                     cfg_ext;
    logic [rme_pkg::VALUE_BITS-1:0]    res_word;
    logic                              out_load;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;

    always_comb begin
        if (i_in.func == rme_pkg::FUNC_DECRYPT) begin
            sel_exp     = r_priv_exp;
            sel_operand = i_in.value;
        end else begin
            sel_exp     = r_pub_exp;
            sel_operand = {{(rme_pkg::VALUE_BITS-rme_pkg::BYTE_BITS){1'b0}},
                           i_in.value[rme_pkg::BYTE_BITS-1:0]};
        end
        sel_pass = (sel_exp[rme_pkg::EXP_BITS-1:1] == '0);
    end

    assign red_start = in_xfer && !sel_pass;
    assign mul_start = (r_state == S_LAUNCH);
    assign cfg_ext   = EW'(i_cfg_data);
    assign acc_ext   = EW'(r_acc);

    always_comb begin
        if (r_pass) begin
            res_word = r_operand;
        end else begin
            res_word = acc_ext[rme_pkg::VALUE_BITS-1:0];
        end
        if (r_func == rme_pkg::FUNC_DECRYPT) begin
            res_word = {{(rme_pkg::VALUE_BITS-rme_pkg::BYTE_BITS){1'b0}},
                        res_word[rme_pkg::BYTE_BITS-1:0]};
        end
    end

    assign out_load = (r_state == S_FINISH) && (!r_out_valid || i_out_ready);

    rme_modred #(
        .WIDTH(W)
    ) u_modred (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (red_start),
        .i_value   (sel_operand),
        .i_modulus (r_modulus),
        .o_done    (red_done),
        .o_rem     (red_rem)
    );

    rme_mulmod #(
        .WIDTH(W)
    ) u_mul_acc (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_a       (r_acc),
        .i_b       (r_base),
        .i_modulus (r_modulus),
        .o_done    (acc_done),
        .o_product (acc_prod)
    );

    rme_mulmod #(
        .WIDTH(W)
    ) u_mul_sq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_a       (r_base),
        .i_b       (r_base),
        .i_modulus (r_modulus),
        .o_done    (sq_done),
        .o_product (sq_prod)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus  <= W'(1);
            r_pub_exp  <= '0;
            r_priv_exp <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rme_pkg::CFG_MODULUS:          r_modulus  <= cfg_ext[W-1:0];
                rme_pkg::CFG_PUBLIC_EXPONENT:  r_pub_exp  <= i_cfg_data;
                rme_pkg::CFG_PRIVATE_EXPONENT: r_priv_exp <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_state <= sel_pass ? S_FINISH : S_REDUCE;
                    end
                end
                S_REDUCE: begin
                    if (red_done) begin
                        r_state <= S_LAUNCH;
                    end
                end
                S_LAUNCH: begin
                    r_state <= S_POW;
                end
                S_POW: begin
                    if (acc_done && sq_done) begin
                        r_state <= (r_exp[rme_pkg::EXP_BITS-1:1] == '0) ? S_FINISH : S_LAUNCH;
                    end
                end
                S_FINISH: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_func    <= i_in.func;
            r_last    <= i_in.last_item;
            r_pass    <= sel_pass;
            r_operand <= sel_operand;
            r_exp     <= sel_exp;
        end
        if ((r_state == S_REDUCE) && red_done) begin
            r_base <= red_rem;
            r_acc  <= (r_modulus == W'(1)) ? '0 : W'(1);
        end
        if ((r_state == S_POW) && acc_done && sq_done) begin
            if (r_exp[0]) begin
                r_acc <= acc_prod;
            end
            r_base <= sq_prod;
            r_exp  <= {1'b0, r_exp[rme_pkg::EXP_BITS-1:1]};
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.result   <= res_word;
            r_out.last_out <= r_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

/* hdl/rme_checker.sv */
// port-level checker for the modular exponentiation block and its bind
module rme_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               o_in_ready,
    input  rme_pkg::t_in_item  i_in,
    input  logic               o_out_valid,
    input  logic               i_out_ready,
    input  rme_pkg::t_out_item o_out
);

    logic r_func;
    logic r_last;
    logic r_out_open;
    logic in_xfer;
    logic new_out;

    assign in_xfer = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_func <= rme_pkg::FUNC_ENCRYPT;
            r_last <= 1'b0;
        end else if (in_xfer) begin
            r_func <= i_in.func;
            r_last <= i_in.last_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_open <= 1'b1;
        end else begin
            r_out_open <= !o_out_valid || i_out_ready;
        end
    end

    // a result that just entered the output belongs to the last input transfer
    assign new_out = o_out_valid && r_out_open;

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !o_in_ready)
        else $error("input ready right after a transfer");

    a_out_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("stalled output changed");

    a_last_copied: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        new_out |-> (o_out.last_out == r_last))
        else $error("last flag does not match its input");

    a_decrypt_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        new_out && (r_func == rme_pkg::FUNC_DECRYPT)
            |-> (o_out.result[rme_pkg::VALUE_BITS-1:rme_pkg::BYTE_BITS] == '0))
        else $error("decrypt result wider than a byte");

endmodule

bind rsa_modular_exponentiation rme_checker u_rme_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);
